// ----- sv/iee_pkg.sv -----
// Shared types, token and status codes, and fixed-point helpers for the infix evaluator.
// No dependencies; imported by every module of the block.
package iee_pkg;
	localparam int OP_W = 3;
	localparam int VAL_W = 48;
	localparam int ST_W = 2;
	localparam int FB = 16;
	localparam int OD = 32;
	localparam int VD = 32;
	localparam int OA_W = $clog2(OD);
	localparam int VA_W = $clog2(VD);
	localparam int OC_W = $clog2(OD + 1);
	localparam int VC_W = $clog2(VD + 1);
	localparam int QD = 4;
	localparam int QA_W = $clog2(QD);
	localparam int NW = VAL_W + FB;
	localparam int DC_W = $clog2(NW);
	localparam int HW = VAL_W / 2;
	localparam int PW = 2 * VAL_W;

	localparam logic [OP_W-1:0] TK_NUM = 3'd0;
	localparam logic [OP_W-1:0] TK_OPEN = 3'd1;
	localparam logic [OP_W-1:0] TK_CLOSE = 3'd2;
	localparam logic [OP_W-1:0] TK_ADD = 3'd3;
	localparam logic [OP_W-1:0] TK_SUB = 3'd4;
	localparam logic [OP_W-1:0] TK_MUL = 3'd5;
	localparam logic [OP_W-1:0] TK_DIV = 3'd6;
	localparam logic [OP_W-1:0] TK_END = 3'd7;

	localparam logic [ST_W-1:0] ST_OK = 2'd0;
	localparam logic [ST_W-1:0] ST_DIV0 = 2'd1;
	localparam logic [ST_W-1:0] ST_SAT = 2'd2;
	localparam logic [ST_W-1:0] ST_BAD = 2'd3;

	localparam logic [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
	localparam logic [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};
	localparam logic [PW-1:0] MAG_MAX = PW'(VAL_MAX);
	localparam logic [PW-1:0] MAG_MIN = PW'(VAL_MIN);

	typedef struct packed {
		logic [OP_W-1:0] op;
		logic [VAL_W-1:0] val;
	} tok_t;

	typedef struct packed {
		logic sat;
		logic [VAL_W-1:0] val;
	} satres_t;

	typedef struct packed {
		logic start;
		logic [OP_W-1:0] op;
		logic [VAL_W-1:0] b;
		logic [VAL_W-1:0] a;
	} alu_req_t;

	typedef struct packed {
		logic done;
		logic sat;
		logic [VAL_W-1:0] val;
	} alu_rsp_t;

	function automatic logic [1:0] rank(input logic [OP_W-1:0] op);
		if (op == TK_MUL || op == TK_DIV) return 2'd3;
		if (op == TK_ADD || op == TK_SUB) return 2'd2;
		return 2'd1;
	endfunction

	function automatic satres_t fx_sat(input logic neg, input logic [PW-1:0] m);
		satres_t r;
		if (neg) begin
			r.sat = m > MAG_MIN;
			r.val = r.sat ? VAL_MIN : VAL_W'(0) - m[VAL_W-1:0];
		end else begin
			r.sat = m > MAG_MAX;
			r.val = r.sat ? VAL_MAX : m[VAL_W-1:0];
		end
		return r;
	endfunction
endpackage

// ----- sv/iee_tokq.sv -----
// Front end: accepts tokens from the input stream and queues them for the evaluator.
// Depends on iee_pkg.
module iee_tokq import iee_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [VAL_W-1:0]  s_tdata,   // [47:0] number_value
	input  logic [OP_W-1:0]   s_tuser,   // [2:0] operation
	output tok_t              tok,
	output logic              tok_valid,
	input  logic              tok_ready
);
	tok_t              q_q [QD];
	logic [QA_W-1:0]   wp_q, rp_q;
	logic [QA_W:0]     cnt_q;
	logic              push, pop;

	assign s_tready = cnt_q != (QA_W+1)'(QD);
	assign tok_valid = cnt_q != '0;
	assign tok = q_q[rp_q];
	assign push = s_tvalid && s_tready;
	assign pop = tok_valid && tok_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 1'b1;
			if (pop) rp_q <= rp_q + 1'b1;
			if (push && !pop) cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			q_q[wp_q].op <= s_tuser;
			q_q[wp_q].val <= (s_tuser == TK_NUM) ? s_tdata : '0;
		end
	end
endmodule

// ----- sv/iee_alu.sv -----
// Arithmetic unit: saturating add/subtract, 4-step 24x24 multiply, bit-serial divide.
// Depends on iee_pkg.
module iee_alu import iee_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  alu_req_t req,
	output alu_rsp_t rsp
);
	localparam logic [1:0] A_IDLE = 2'd0;
	localparam logic [1:0] A_MUL = 2'd1;
	localparam logic [1:0] A_DIV = 2'd2;
	localparam logic [1:0] A_FIN = 2'd3;

	logic [1:0]        st_q;
	logic              done_q, sat_q, neg_q;
	logic [VAL_W-1:0]  val_q, x_q, y_q, rem_q;
	logic [PW-1:0]     acc_q, pp_ext;
	logic [VAL_W-1:0]  pp_q;
	logic [1:0]        psh_q;
	logic [2:0]        stp_q;
	logic [NW-1:0]     dvd_q, quo_q;
	logic [DC_W-1:0]   dc_q;
	logic [VAL_W-1:0]  mag_a, mag_b;
	logic [VAL_W:0]    sum, r2, diff;
	logic [HW-1:0]     xs, ys;
	logic              ge;
	satres_t           fin;

	always_comb begin
		mag_a = req.a[VAL_W-1] ? VAL_W'(0) - req.a : req.a;
		mag_b = req.b[VAL_W-1] ? VAL_W'(0) - req.b : req.b;
		if (req.op == TK_SUB) sum = {req.b[VAL_W-1], req.b} - {req.a[VAL_W-1], req.a};
		else sum = {req.b[VAL_W-1], req.b} + {req.a[VAL_W-1], req.a};
		xs = stp_q[0] ? x_q[VAL_W-1:HW] : x_q[HW-1:0];
		ys = stp_q[1] ? y_q[VAL_W-1:HW] : y_q[HW-1:0];
		unique case (psh_q)
			2'd0: pp_ext = PW'(pp_q);
			2'd1: pp_ext = PW'(pp_q) << HW;
			default: pp_ext = PW'(pp_q) << (2 * HW);
		endcase
		r2 = {rem_q, dvd_q[NW-1]};
		diff = r2 - {1'b0, y_q};
		ge = r2 >= {1'b0, y_q};
		fin = fx_sat(neg_q, acc_q >> FB);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= A_IDLE;
			done_q <= 1'b0;
			stp_q <= '0;
			dc_q <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (st_q)
				A_IDLE: begin
					if (req.start) begin
						stp_q <= '0;
						dc_q <= DC_W'(NW - 1);
						if (req.op == TK_MUL) st_q <= A_MUL;
						else if (req.op == TK_DIV) st_q <= A_DIV;
						else done_q <= 1'b1;
					end
				end
				A_MUL: begin
					stp_q <= stp_q + 1'b1;
					if (stp_q == 3'd4) st_q <= A_FIN;
				end
				A_DIV: begin
					dc_q <= dc_q - 1'b1;
					if (dc_q == '0) st_q <= A_FIN;
				end
				A_FIN: begin
					done_q <= 1'b1;
					st_q <= A_IDLE;
				end
				default: st_q <= A_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (st_q)
			A_IDLE: begin
				if (req.start) begin
					neg_q <= req.a[VAL_W-1] ^ req.b[VAL_W-1];
					x_q <= mag_b;
					y_q <= mag_a;
					acc_q <= '0;
					rem_q <= '0;
					quo_q <= '0;
					dvd_q <= NW'(mag_b) << FB;
					sat_q <= sum[VAL_W] != sum[VAL_W-1];
					val_q <= (sum[VAL_W] != sum[VAL_W-1]) ?
						(sum[VAL_W] ? VAL_MIN : VAL_MAX) : sum[VAL_W-1:0];
				end
			end
			A_MUL: begin
				if (stp_q != 3'd4) begin
					pp_q <= VAL_W'(xs * ys);
					psh_q <= {1'b0, stp_q[0]} + {1'b0, stp_q[1]};
				end
				if (stp_q != '0) acc_q <= acc_q + pp_ext;
			end
			A_DIV: begin
				rem_q <= ge ? diff[VAL_W-1:0] : r2[VAL_W-1:0];
				quo_q <= {quo_q[NW-2:0], ge};
				dvd_q <= dvd_q << 1;
				if (dc_q == '0) acc_q <= PW'({quo_q[NW-2:0], ge}) << FB;
			end
			A_FIN: begin
				sat_q <= fin.sat;
				val_q <= fin.val;
			end
			default: ;
		endcase
	end

	assign rsp.done = done_q;
	assign rsp.sat = sat_q;
	assign rsp.val = val_q;
endmodule

// ----- sv/iee_core.sv -----
// Back end: operator and value stacks, shunting-yard sequencer and result register.
// Depends on iee_pkg; drives iee_alu through alu_req_t / alu_rsp_t.
module iee_core import iee_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  tok_t              tok,
	input  logic              tok_valid,
	output logic              tok_ready,
	output alu_req_t          req,
	input  alu_rsp_t          rsp,
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [VAL_W-1:0]  m_tdata,
	output logic [ST_W-1:0]   m_tuser
);
	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_LOOP = 4'd1;
	localparam logic [3:0] S_OPCHK = 4'd2;
	localparam logic [3:0] S_APA = 4'd3;
	localparam logic [3:0] S_APB = 4'd4;
	localparam logic [3:0] S_APX = 4'd5;
	localparam logic [3:0] S_APW = 4'd6;
	localparam logic [3:0] S_FIN = 4'd7;
	localparam logic [3:0] S_OUT = 4'd8;

	logic [OP_W-1:0]   omem [OD];
	logic [VAL_W-1:0]  vmem [VD];
	logic [3:0]        state_q, state_d;
	logic [OC_W-1:0]   ocnt_q, ocnt_d, om1;
	logic [VC_W-1:0]   vcnt_q, vcnt_d, vm1, vm2;
	logic [ST_W-1:0]   err_q, err_d;
	logic [OP_W-1:0]   mode_q, mode_d, t_q, t_d, ord_q, owd;
	logic [VAL_W-1:0]  a_q, a_d, vrd_q, vwd;
	logic [VA_W-1:0]   vra, vwa;
	logic [OA_W-1:0]   owa;
	logic              owe, vwe, out_load, aborted, ofull, vfull;
	logic              m_tvalid_q;
	logic [VAL_W-1:0]  m_tdata_q;
	logic [ST_W-1:0]   m_tuser_q;

	assign om1 = ocnt_q - OC_W'(1);
	assign vm1 = vcnt_q - VC_W'(1);
	assign vm2 = vcnt_q - VC_W'(2);
	assign aborted = err_q == ST_DIV0 || err_q == ST_BAD;
	assign ofull = ocnt_q == OC_W'(OD);
	assign vfull = vcnt_q == VC_W'(VD);

	always_comb begin
		state_d = state_q;
		ocnt_d = ocnt_q;
		vcnt_d = vcnt_q;
		err_d = err_q;
		mode_d = mode_q;
		t_d = t_q;
		a_d = a_q;
		owe = 1'b0;
		owa = ocnt_q[OA_W-1:0];
		owd = mode_q;
		vwe = 1'b0;
		vwa = vcnt_q[VA_W-1:0];
		vwd = tok.val;
		vra = vm1[VA_W-1:0];
		req = '0;
		tok_ready = 1'b0;
		out_load = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				tok_ready = 1'b1;
				if (tok_valid) begin
					mode_d = tok.op;
					if (tok.op == TK_END) state_d = S_LOOP;
					else if (!aborted) begin
						if (tok.op == TK_NUM) begin
							if (vfull) err_d = ST_BAD;
							else begin
								vwe = 1'b1;
								vcnt_d = vcnt_q + 1'b1;
							end
						end else if (tok.op == TK_OPEN) begin
							if (ofull) err_d = ST_BAD;
							else begin
								owe = 1'b1;
								owd = TK_OPEN;
								ocnt_d = ocnt_q + 1'b1;
							end
						end else state_d = S_LOOP;
					end
				end
			end
			S_LOOP: begin
				if (aborted) state_d = (mode_q == TK_END) ? S_FIN : S_IDLE;
				else if (ocnt_q == '0) begin
					if (mode_q == TK_END) state_d = S_FIN;
					else begin
						state_d = S_IDLE;
						if (mode_q == TK_CLOSE || ofull) err_d = ST_BAD;
						else begin
							owe = 1'b1;
							ocnt_d = ocnt_q + 1'b1;
						end
					end
				end else state_d = S_OPCHK;
			end
			S_OPCHK: begin
				t_d = ord_q;
				if (mode_q == TK_CLOSE || mode_q == TK_END) begin
					ocnt_d = om1;
					if (ord_q != TK_OPEN) state_d = S_APA;
					else state_d = (mode_q == TK_CLOSE) ? S_IDLE : S_LOOP;
				end else if (ord_q == TK_OPEN || rank(ord_q) < rank(mode_q)) begin
					state_d = S_IDLE;
					if (ofull) err_d = ST_BAD;
					else begin
						owe = 1'b1;
						ocnt_d = ocnt_q + 1'b1;
					end
				end else begin
					ocnt_d = om1;
					state_d = S_APA;
				end
			end
			S_APA: begin
				if (vcnt_q < VC_W'(2)) begin
					err_d = ST_BAD;
					state_d = S_LOOP;
				end else state_d = S_APB;
			end
			S_APB: begin
				a_d = vrd_q;
				vra = vm2[VA_W-1:0];
				state_d = S_APX;
			end
			S_APX: begin
				if (t_q == TK_DIV && a_q == '0) begin
					err_d = ST_DIV0;
					state_d = S_LOOP;
				end else begin
					req.start = 1'b1;
					req.op = t_q;
					req.a = a_q;
					req.b = vrd_q;
					state_d = S_APW;
				end
			end
			S_APW: begin
				if (rsp.done) begin
					vwe = 1'b1;
					vwa = vm2[VA_W-1:0];
					vwd = rsp.val;
					vcnt_d = vm1;
					if (rsp.sat && err_q == ST_OK) err_d = ST_SAT;
					state_d = S_LOOP;
				end
			end
			S_FIN: begin
				vra = '0;
				if (!aborted && vcnt_q != VC_W'(1)) err_d = ST_BAD;
				state_d = S_OUT;
			end
			S_OUT: begin
				vra = '0;
				if (!m_tvalid_q || m_tready) begin
					out_load = 1'b1;
					ocnt_d = '0;
					vcnt_d = '0;
					err_d = ST_OK;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ocnt_q <= '0;
			vcnt_q <= '0;
			err_q <= ST_OK;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			ocnt_q <= ocnt_d;
			vcnt_q <= vcnt_d;
			err_q <= err_d;
			if (out_load) m_tvalid_q <= 1'b1;
			else if (m_tready) m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		mode_q <= mode_d;
		t_q <= t_d;
		a_q <= a_d;
		if (out_load) begin
			m_tuser_q <= err_q;
			m_tdata_q <= aborted ? '0 : vrd_q;
		end
	end

	always_ff @(posedge clk) begin
		if (owe) omem[owa] <= owd;
		ord_q <= omem[om1[OA_W-1:0]];
	end

	always_ff @(posedge clk) begin
		if (vwe) vmem[vwa] <= vwd;
		vrd_q <= vmem[vra];
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata = m_tdata_q;
	assign m_tuser = m_tuser_q;

	a_vcnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		vcnt_q <= VC_W'(VD)) else $error("value count out of range");
	a_ocnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		ocnt_q <= OC_W'(OD)) else $error("operator count out of range");
	a_abort_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_load && aborted |=> m_tdata == '0) else $error("aborted result not zero");
	a_alu_wait: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |=> state_q == S_APW) else $error("alu start outside apply");
endmodule

// ----- sv/infix_expression_evaluator.sv -----
// Infix expression evaluator top level: token queue, stack sequencer and arithmetic unit.
// A number or open bracket is pushed in the idle state after the 4-entry token queue; each
// operator reduction steps through S_LOOP, S_OPCHK, S_APA, S_APB, S_APX and S_APW, the last
// waiting on the arithmetic unit: multiply forms four 24x24 partial products, divide one quotient
// bit per cycle. An end mark emits its result via S_FIN and S_OUT; throughput is data dependent.
// Reset clears counts, status and handshakes at once; stack contents are not cleared.
module infix_expression_evaluator import iee_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [VAL_W-1:0]  s_tdata,   // [47:0] number_value
	input  logic [OP_W-1:0]   s_tuser,   // [2:0] operation
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [VAL_W-1:0]  m_tdata,   // [47:0] result_value
	output logic [ST_W-1:0]   m_tuser    // [1:0] status
);
	tok_t     tok;
	logic     tok_valid, tok_ready;
	alu_req_t req;
	alu_rsp_t rsp;

	iee_tokq u_tokq (
		.clk, .arst_n, .s_tvalid, .s_tready, .s_tdata, .s_tuser,
		.tok, .tok_valid, .tok_ready
	);

	iee_alu u_alu (.clk, .arst_n, .req, .rsp);

	iee_core u_core (
		.clk, .arst_n, .tok, .tok_valid, .tok_ready, .req, .rsp,
		.m_tvalid, .m_tready, .m_tdata, .m_tuser
	);
endmodule

// ----- tb/tb.sv -----
// Self-checking bench for the infix expression evaluator: token driver, result monitor, scoreboard.
// Depends on iee_pkg and infix_expression_evaluator; expected results come from a built-in evaluator.
`timescale 1ns / 100ps
module tb;
	import iee_pkg::*;

	localparam int CYCLE_LIMIT = 3000000;

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [VAL_W-1:0] s_tdata;
	logic [OP_W-1:0] s_tuser;
	logic m_tvalid;
	logic m_tready;
	logic [VAL_W-1:0] m_tdata;
	logic [ST_W-1:0] m_tuser;

	typedef struct packed {
		logic [VAL_W-1:0] val;
		logic [ST_W-1:0] st;
	} answer_t;

	tok_t token_q[$];
	answer_t answer_q[$];
	int errors;
	int cycles;
	int send_idle;
	int recv_idle;
	bit stim_done;

	// evaluator state
	logic [OP_W-1:0] op_stk[OD];
	int op_cnt;
	logic signed [VAL_W-1:0] val_stk[VD];
	int val_cnt;
	logic [ST_W-1:0] err_st;

	infix_expression_evaluator i_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic bit halted();
		return err_st == ST_DIV0 || err_st == ST_BAD;
	endfunction

	function automatic void mark_bad();
		if (!halted()) err_st = ST_BAD;
	endfunction

	function automatic logic [VAL_W-1:0] clamp(input logic signed [127:0] x);
		if (x > 128'sh7FFFFFFFFFFF) begin
			if (err_st == ST_OK) err_st = ST_SAT;
			return VAL_MAX;
		end
		if (x < -128'sh800000000000) begin
			if (err_st == ST_OK) err_st = ST_SAT;
			return VAL_MIN;
		end
		return x[VAL_W-1:0];
	endfunction

	function automatic void reduce(input logic [OP_W-1:0] op);
		logic signed [127:0] a, b, r, m;
		logic neg;
		if (halted()) return;
		if (val_cnt < 2) begin
			mark_bad();
			return;
		end
		a = val_stk[val_cnt-1];
		b = val_stk[val_cnt-2];
		neg = (a < 0) != (b < 0);
		case (op)
			TK_ADD: r = b + a;
			TK_SUB: r = b - a;
			TK_MUL: begin
				m = ((a < 0 ? -a : a) * (b < 0 ? -b : b)) >>> FB;
				r = neg ? -m : m;
			end
			default: begin
				if (a == 0) begin
					err_st = ST_DIV0;
					return;
				end
				m = ((b < 0 ? -b : b) <<< FB) / (a < 0 ? -a : a);
				r = neg ? -m : m;
			end
		endcase
		val_cnt--;
		val_stk[val_cnt-1] = clamp(r);
	endfunction

	function automatic void push_op(input logic [OP_W-1:0] op);
		if (op_cnt >= OD) mark_bad();
		else op_stk[op_cnt++] = op;
	endfunction

	function automatic void evaluate_token(input tok_t t);
		logic [OP_W-1:0] top;
		answer_t ans;
		if (t.op == TK_END) begin
			while (op_cnt > 0 && !halted()) begin
				top = op_stk[--op_cnt];
				if (top != TK_OPEN) reduce(top);
			end
			if (!halted() && val_cnt != 1) mark_bad();
			ans.val = halted() ? '0 : val_stk[0];
			ans.st = err_st;
			answer_q.push_back(ans);
			op_cnt = 0;
			val_cnt = 0;
			err_st = ST_OK;
			return;
		end
		if (halted()) return;
		case (t.op)
			TK_NUM: begin
				if (val_cnt >= VD) mark_bad();
				else val_stk[val_cnt++] = t.val;
			end
			TK_OPEN: push_op(TK_OPEN);
			TK_CLOSE: begin
				forever begin
					if (op_cnt == 0) begin
						mark_bad();
						break;
					end
					top = op_stk[--op_cnt];
					if (top == TK_OPEN) break;
					reduce(top);
					if (halted()) break;
				end
			end
			default: begin
				while (op_cnt > 0 && !halted()) begin
					top = op_stk[op_cnt-1];
					if (top == TK_OPEN || rank(top) < rank(t.op)) break;
					op_cnt--;
					reduce(top);
				end
				if (!halted()) push_op(t.op);
			end
		endcase
	endfunction

	task automatic report_mismatch(input string what, input logic [VAL_W-1:0] got,
			input logic [VAL_W-1:0] want);
		$display("%0t: %s got %h want %h", $time, what, got, want);
		errors++;
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= TK_NUM;
		end else begin
			if (s_tvalid && s_tready) begin
				evaluate_token('{op: s_tuser, val: s_tdata});
				void'(token_q.pop_front());
			end
			if (!s_tvalid || s_tready) begin
				if (token_q.size() > 0 && $urandom_range(99) >= send_idle) begin
					s_tvalid <= 1'b1;
					s_tuser <= token_q[0].op;
					s_tdata <= token_q[0].val;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// monitor and receiver stalls
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			m_tready <= $urandom_range(99) >= recv_idle;
			if (m_tvalid && m_tready) begin
				if (answer_q.size() == 0) begin
					report_mismatch("unexpected result", m_tdata, '0);
				end else begin
					if (m_tdata !== answer_q[0].val)
						report_mismatch("result_value", m_tdata, answer_q[0].val);
					if (m_tuser !== answer_q[0].st)
						report_mismatch("status", VAL_W'(m_tuser), VAL_W'(answer_q[0].st));
					void'(answer_q.pop_front());
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	function automatic logic [VAL_W-1:0] rand_value();
		case ($urandom_range(5))
			0: return VAL_MAX;
			1: return VAL_MIN;
			2: return '0;
			3: return VAL_W'({$urandom, $urandom});
			4: return VAL_W'($urandom_range(8) << FB);
			default: return VAL_W'(signed'($urandom_range(2000)) - 1000) <<< ($urandom_range(20));
		endcase
	endfunction

	function automatic void add_tok(input logic [OP_W-1:0] op, input logic [VAL_W-1:0] v);
		tok_t t;
		t.op = op;
		t.val = v;
		token_q.push_back(t);
	endfunction

	function automatic logic [OP_W-1:0] rand_binop();
		return TK_ADD + OP_W'($urandom_range(3));
	endfunction

	// well-formed expression with random nesting; returns tokens added
	function automatic int gen_expr(input int depth);
		int n, terms;
		n = 0;
		terms = $urandom_range(1, 4);
		for (int i = 0; i < terms; i++) begin
			if (i > 0) begin
				add_tok(rand_binop(), VAL_W'($urandom));
				n++;
			end
			if (depth > 0 && $urandom_range(3) == 0) begin
				add_tok(TK_OPEN, '0);
				n += gen_expr(depth - 1) + 2;
				add_tok(TK_CLOSE, '0);
			end else begin
				add_tok(TK_NUM, rand_value());
				n++;
			end
		end
		return n;
	endfunction

	task automatic drain();
		while (token_q.size() > 0 || answer_q.size() > 0) @(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	initial begin
		int count;
		int phase_len;
		errors = 0;
		cycles = 0;
		send_idle = 30;
		recv_idle = 85;
		op_cnt = 0;
		val_cnt = 0;
		err_st = ST_OK;
		arst_n = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// directed: empty, extremes, saturation, div by zero, brackets, overflow
		add_tok(TK_END, '0);
		add_tok(TK_NUM, VAL_MAX); add_tok(TK_ADD, '0); add_tok(TK_NUM, VAL_MAX);
		add_tok(TK_END, '0);
		add_tok(TK_NUM, VAL_MIN); add_tok(TK_MUL, '0); add_tok(TK_NUM, VAL_MIN);
		add_tok(TK_END, '0);
		add_tok(TK_NUM, 48'h30000); add_tok(TK_DIV, '0); add_tok(TK_NUM, '0);
		add_tok(TK_ADD, '0); add_tok(TK_END, '0);
		add_tok(TK_OPEN, '0); add_tok(TK_NUM, 48'h10000); add_tok(TK_SUB, '0);
		add_tok(TK_NUM, 48'hFFFFFFFE0000); add_tok(TK_CLOSE, '0); add_tok(TK_DIV, '0);
		add_tok(TK_NUM, 48'h30000); add_tok(TK_END, '0);
		add_tok(TK_CLOSE, '0); add_tok(TK_END, '0);
		add_tok(TK_ADD, '0); add_tok(TK_END, '0);
		add_tok(TK_NUM, 48'h1); add_tok(TK_NUM, 48'h2); add_tok(TK_END, '0);
		for (int i = 0; i < 33; i++) add_tok(TK_OPEN, '0);
		add_tok(TK_END, '0);
		for (int i = 0; i < 33; i++) add_tok(TK_NUM, VAL_W'(i));
		add_tok(TK_END, '0);
		add_tok(TK_OPEN, '0); add_tok(TK_NUM, 48'h7); add_tok(TK_END, '0);

		count = 0;
		for (int phase = 0; phase < 3; phase++) begin
			phase_len = (phase + 1) * 317;
			while (count < phase_len) begin
				if ($urandom_range(9) < 8) begin
					count += gen_expr(3);
				end else begin
					for (int k = $urandom_range(1, 6); k > 0; k--) begin
						add_tok(OP_W'($urandom_range(6)), rand_value());
						count++;
					end
				end
				add_tok(TK_END, '0);
				count++;
			end
			drain();
			if (phase == 0) begin
				send_idle = 85;
				recv_idle = 30;
			end else begin
				send_idle = 0;
				recv_idle = 0;
			end
		end
		if (errors == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end
endmodule
